// File: rtl/core/refcount_promoted_lru_victim_defines.svh
// Assertion helpers shared by the RTL.
`ifndef REFCOUNT_PROMOTED_LRU_VICTIM_DEFINES_SVH
`define REFCOUNT_PROMOTED_LRU_VICTIM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPLRU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rplru: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RPLRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rplru: next-cycle check failed");

`endif

// File: rtl/core/rplru_pkg.sv
package rplru_pkg;

   // Fixed field widths of the ports
   localparam int KIND_BITS   = 2;
   localparam int SET_FBITS   = 6;
   localparam int WAY_FBITS   = 3;
   localparam int TIME_FBITS  = 32;
   localparam int THRESH_BITS = 8;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd10;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_INVALIDATE = 2'd0,
      KIND_TOUCH      = 2'd1,
      KIND_INSERT     = 2'd2,
      KIND_QUERY      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'd0,
      ST_IDLE  = 3'd1,
      ST_EXEC  = 3'd2,
      ST_SCAN  = 3'd3,
      ST_DONE  = 3'd4
   } state_type;

endpackage

// File: rtl/core/refcount_promoted_lru_victim.sv
// Channel   Handshake                Word
// --------  -----------------------  ----------------------------------------------
// req       req_valid / req_ready    kind, set_index, way_index, current_time
// rsp       rsp_valid / rsp_ready    victim_way (victim queries only)
// csr       csr_valid / csr_ready    promote_threshold (always ready)
//
// Invalidate, touch and insert: accept with row read, then write-back.
// A victim query: row read, a seed step on way 0, WAYS-1 compare steps over the registered
// row (skipped for a set out of range), then the result loads into the output register.
// One request is in flight at a time; the set row read and write share one memory port pair.
// After reset a clearing pass zeroes all SETS rows, one per cycle,
// with req_ready low; threshold writes are taken throughout.
// A finished query waits while the output register is still full.
`include "refcount_promoted_lru_victim_defines.svh"

module refcount_promoted_lru_victim
   import rplru_pkg::*;
#(
   parameter int SETS       = 64,
   parameter int WAYS       = 8,
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_BITS-1:0]   req_kind,
   input  logic [SET_FBITS-1:0]   req_set_index,
   input  logic [WAY_FBITS-1:0]   req_way_index,
   input  logic [TIME_FBITS-1:0]  req_current_time,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WAY_FBITS-1:0]   rsp_victim_way,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [THRESH_BITS-1:0] csr_promote_threshold
);

   localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_AW = $clog2(WAYS);
   localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(SETS - 1);
   localparam logic [WAY_AW-1:0] LAST_WAY = WAY_AW'(WAYS - 1);

   typedef logic [WAYS-1:0][TIME_BITS-1:0]  stamp_row_type;
   typedef logic [WAYS-1:0][COUNT_BITS-1:0] count_row_type;

   // Set rows: one memory for stamps, one for counts
   stamp_row_type stamp_mem [SETS];
   count_row_type count_mem [SETS];

   state_type state_ff, state_in;

   logic [SET_AW-1:0]      clr_ptr_ff, clr_ptr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WAY_FBITS-1:0]   rsp_way_ff, rsp_way_in;
   logic [THRESH_BITS-1:0] thresh_ff, thresh_in;

   kind_type               kind_ff, kind_in;
   logic                   set_ok_ff, set_ok_in;
   logic                   way_ok_ff, way_ok_in;
   logic [SET_AW-1:0]      addr_ff, addr_in;
   logic [WAY_AW-1:0]      way_ff, way_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic [WAY_AW-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [WAY_AW-1:0]      best_way_ff, best_way_in;
   logic [TIME_BITS-1:0]   best_stamp_ff, best_stamp_in;

   stamp_row_type stamp_rd_ff;
   count_row_type count_rd_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  rsp_free;
   logic                  mem_wr_en;
   logic [SET_AW-1:0]     mem_wr_addr;
   stamp_row_type         mem_wr_stamp;
   count_row_type         mem_wr_count;
   stamp_row_type         stamp_row_new;
   count_row_type         count_row_new;
   logic [COUNT_BITS-1:0] cnt_old;
   logic [COUNT_BITS-1:0] cnt_bump;
   logic                  promote;
   logic                  update_ok;

   logic [SET_AW+SET_FBITS-1:0]    set_wide;
   logic [WAY_AW+WAY_FBITS-1:0]    way_wide;
   logic [TIME_BITS+TIME_FBITS-1:0] time_wide;
   logic [WAY_AW+WAY_FBITS-1:0]    best_wide;

   // Handshake terms
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

   // Fit the request fields to the storage widths
   assign set_wide  = {{SET_AW{1'b0}}, req_set_index};
   assign way_wide  = {{WAY_AW{1'b0}}, req_way_index};
   assign time_wide = {{TIME_BITS{1'b0}}, req_current_time};
   assign best_wide = {{WAY_FBITS{1'b0}}, best_way_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (kind_ff != KIND_QUERY) begin
               state_in = ST_IDLE;
            end else if (set_ok_ff) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_ptr_ff == LAST_WAY) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Control outputs per state
   always_comb begin
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_stamp = stamp_row_new;
      mem_wr_count = count_row_new;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = clr_ptr_ff;
            mem_wr_stamp = '0;
            mem_wr_count = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            mem_wr_en = update_ok;
         end
         ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Modify the selected way of the row
   assign update_ok = (kind_ff != KIND_QUERY) && set_ok_ff && way_ok_ff;
   assign cnt_old   = count_rd_ff[way_ff];
   assign cnt_bump  = (cnt_old == {COUNT_BITS{1'b1}}) ? cnt_old : cnt_old + 1'b1;
   assign promote   = {{THRESH_BITS{1'b0}}, cnt_bump} > {{COUNT_BITS{1'b0}}, thresh_ff};

   always_comb begin
      stamp_row_new = stamp_rd_ff;
      count_row_new = count_rd_ff;
      case (kind_ff)
         KIND_INVALIDATE: begin
            stamp_row_new[way_ff] = '0;
            count_row_new[way_ff] = '0;
         end
         KIND_TOUCH: begin
            count_row_new[way_ff] = cnt_bump;
            stamp_row_new[way_ff] = promote ? time_ff : '0;
         end
         KIND_INSERT: begin
            count_row_new[way_ff] = cnt_bump;
            stamp_row_new[way_ff] = '0;
         end
         default: begin
            stamp_row_new = stamp_rd_ff;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      clr_ptr_in    = clr_ptr_ff;
      thresh_in     = csr_valid ? csr_promote_threshold : thresh_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_way_in    = rsp_way_ff;
      kind_in       = kind_ff;
      set_ok_in     = set_ok_ff;
      way_ok_in     = way_ok_ff;
      addr_in       = addr_ff;
      way_in        = way_ff;
      time_in       = time_ff;
      scan_ptr_in   = scan_ptr_ff;
      best_way_in   = best_way_ff;
      best_stamp_in = best_stamp_ff;

      // advance the clearing pointer
      if (state_ff == ST_CLEAR) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
      end

      // capture the request word
      if (req_accept) begin
         kind_in   = kind_type'(req_kind);
         set_ok_in = int'(req_set_index) < SETS;
         way_ok_in = int'(req_way_index) < WAYS;
         addr_in   = set_wide[SET_AW-1:0];
         way_in    = way_wide[WAY_AW-1:0];
         time_in   = time_wide[TIME_BITS-1:0];
      end

      // seed the search with way 0, or report way 0 for a set out of range
      if (state_ff == ST_EXEC) begin
         best_way_in   = '0;
         best_stamp_in = stamp_rd_ff[0];
         scan_ptr_in   = WAY_AW'(1);
      end

      // step the search one way per cycle, strict compare keeps the lowest way
      if (state_ff == ST_SCAN) begin
         if (stamp_rd_ff[scan_ptr_ff] < best_stamp_ff) begin
            best_way_in   = scan_ptr_ff;
            best_stamp_in = stamp_rd_ff[scan_ptr_ff];
         end
         scan_ptr_in = scan_ptr_ff + 1'b1;
      end

      // drop a taken word, load a finished one
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_way_in   = best_wide[WAY_FBITS-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_way_ff    <= rsp_way_in;
      kind_ff       <= kind_in;
      set_ok_ff     <= set_ok_in;
      way_ok_ff     <= way_ok_in;
      addr_ff       <= addr_in;
      way_ff        <= way_in;
      time_ff       <= time_in;
      scan_ptr_ff   <= scan_ptr_in;
      best_way_ff   <= best_way_in;
      best_stamp_ff <= best_stamp_in;
   end

   // Set row memories: write back a row, read a row on accept
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         stamp_mem[mem_wr_addr] <= mem_wr_stamp;
         count_mem[mem_wr_addr] <= mem_wr_count;
      end
      if (req_accept) begin
         stamp_rd_ff <= stamp_mem[set_wide[SET_AW-1:0]];
         count_rd_ff <= count_mem[set_wide[SET_AW-1:0]];
      end
   end

   // Checks
   `RPLRU_ASSERT_NOW(a_no_write_on_read, clock, reset, mem_wr_en, !req_accept)
   `RPLRU_ASSERT_NOW(a_load_into_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready)
   `RPLRU_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_accept, state_ff == ST_EXEC)
   `RPLRU_ASSERT_NOW(a_best_behind_scan, clock, reset, state_ff == ST_SCAN,
                     best_way_ff < scan_ptr_ff)

endmodule

// File: tb/refcount_promoted_lru_victim_tb.sv
`timescale 1ns / 1ps

module refcount_promoted_lru_victim_tb
   import rplru_pkg::*;
();

   localparam int STALL_LIMIT = 3000;   // cycles with no word moving on any channel
   localparam int SETTLE      = 16;     // quiet cycles before a threshold write
   localparam int HOLD_OFF    = 300;    // one long receiver stall to back the block up
   localparam int HOLD_AT     = 60;     // victim word count that triggers it

   // Shadow of the replacement state; predicts the victim of each query
   class lru_victim_tracker;
      logic [TIME_FBITS-1:0]  stamp_of [512];
      logic [7:0]             refs_of  [512];
      logic [THRESH_BITS-1:0] threshold;
      logic [WAY_FBITS-1:0]   pending_victims [$];
      int                     mismatch_count;

      function new();
         foreach (stamp_of[i]) begin
            stamp_of[i] = '0;
            refs_of[i]  = '0;
         end
         threshold      = THRESH_RESET;
         mismatch_count = 0;
      endfunction

      function int pending();
         return pending_victims.size();
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      // Apply one accepted request word to the shadow state
      function void note_request(kind_type k, logic [SET_FBITS-1:0] s,
                                 logic [WAY_FBITS-1:0] w, logic [TIME_FBITS-1:0] now_stamp);
         int base;
         int slot;
         int best;
         base = int'(s) * 8;
         slot = base + int'(w);
         case (k)
            KIND_QUERY: begin
               // oldest stamp wins, lowest way on ties
               best = 0;
               for (int i = 1; i < 8; i++)
                  if (stamp_of[base + i] < stamp_of[base + best]) best = i;
               pending_victims.push_back(best[WAY_FBITS-1:0]);
            end
            KIND_INVALIDATE: begin
               stamp_of[slot] = '0;
               refs_of[slot]  = '0;
            end
            KIND_TOUCH: begin
               if (refs_of[slot] != 8'hFF) refs_of[slot] = refs_of[slot] + 8'd1;
               stamp_of[slot] = (refs_of[slot] > threshold) ? now_stamp : '0;
            end
            default: begin
               stamp_of[slot] = '0;
               if (refs_of[slot] != 8'hFF) refs_of[slot] = refs_of[slot] + 8'd1;
            end
         endcase
      endfunction

      // Compare one victim word with the oldest prediction
      task check_victim(logic [WAY_FBITS-1:0] way);
         logic [WAY_FBITS-1:0] want;
         if (pending_victims.size() == 0) begin
            report($sformatf("victim word %0d with no query outstanding", way));
         end else begin
            want = pending_victims.pop_front();
            if (way !== want)
               report($sformatf("victim_way got %0d, want %0d", way, want));
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [KIND_BITS-1:0]   req_kind;
   logic [SET_FBITS-1:0]   req_set_index;
   logic [WAY_FBITS-1:0]   req_way_index;
   logic [TIME_FBITS-1:0]  req_current_time;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [WAY_FBITS-1:0]   rsp_victim_way;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [THRESH_BITS-1:0] csr_promote_threshold;

   lru_victim_tracker tracker = new();

   int  sent_count = 0;
   bit  send_calm  = 0;
   int  idle_cycles = 0;

   refcount_promoted_lru_victim DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_set_index         (req_set_index),
      .req_way_index         (req_way_index),
      .req_current_time      (req_current_time),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_victim_way        (rsp_victim_way),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_promote_threshold (csr_promote_threshold)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one request word after a random gap; hold valid until accepted
   task send_request(kind_type k, logic [SET_FBITS-1:0] s, logic [WAY_FBITS-1:0] w,
                     logic [TIME_FBITS-1:0] now_stamp);
      int gap;
      if (sent_count % 20 == 0) send_calm = ($urandom_range(0, 2) == 0);
      gap = send_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= k;
      req_set_index    <= s;
      req_way_index    <= w;
      req_current_time <= now_stamp;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(k, s, w, now_stamp);
      sent_count++;
   endtask

   // Drain all victims, let the last update retire, then write the threshold
   task load_threshold(logic [THRESH_BITS-1:0] value);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid             <= 1'b1;
      csr_promote_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.threshold = value;
   endtask

   function logic [TIME_FBITS-1:0] pick_stamp();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Hammer one way past count saturation; threshold 254 promotes only when saturated
   task hammer_phase(int n);
      logic [SET_FBITS-1:0] hot_set;
      logic [WAY_FBITS-1:0] hot_way;
      int roll;
      load_threshold(8'd254);
      hot_set = SET_FBITS'($urandom_range(1, 62));
      hot_way = WAY_FBITS'($urandom_range(0, 7));
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 64)
            send_request(KIND_TOUCH, hot_set, hot_way, pick_stamp());
         else if (roll < 92)
            send_request(KIND_INSERT, hot_set, hot_way, pick_stamp());
         else if (roll < 96)
            send_request(KIND_QUERY, hot_set, WAY_FBITS'($urandom_range(0, 7)),
                         pick_stamp());
         else
            send_request(KIND_TOUCH, hot_set, hot_way + WAY_FBITS'($urandom_range(1, 7)),
                         pick_stamp());
      end
   endtask

   // Mixed traffic, mostly on two hot sets so state builds up between queries
   task random_phase(int n, logic [THRESH_BITS-1:0] thr);
      logic [SET_FBITS-1:0] hot [2];
      logic [SET_FBITS-1:0] s;
      int roll;
      load_threshold(thr);
      hot[0] = SET_FBITS'($urandom_range(0, 63));
      hot[1] = SET_FBITS'($urandom_range(0, 63));
      for (int i = 0; i < n; i++) begin
         s = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 1)]
                                         : SET_FBITS'($urandom_range(0, 63));
         roll = $urandom_range(0, 99);
         if (roll < 25)
            send_request(KIND_QUERY, s, WAY_FBITS'($urandom_range(0, 7)), pick_stamp());
         else if (roll < 65)
            send_request(KIND_TOUCH, s, WAY_FBITS'($urandom_range(0, 7)), pick_stamp());
         else if (roll < 85)
            send_request(KIND_INSERT, s, WAY_FBITS'($urandom_range(0, 7)), pick_stamp());
         else
            send_request(KIND_INVALIDATE, s, WAY_FBITS'($urandom_range(0, 7)),
                         pick_stamp());
      end
   endtask

   // Stimulus
   initial begin
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_kind              <= KIND_INVALIDATE;
      req_set_index         <= '0;
      req_way_index         <= '0;
      req_current_time      <= '0;
      csr_valid             <= 1'b0;
      csr_promote_threshold <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: every touch promotes at threshold 0
      load_threshold(8'd0);
      send_request(KIND_QUERY, 6'd0, 3'd0, '0);             // empty set -> way 0
      send_request(KIND_TOUCH, 6'd0, 3'd5, '1);
      send_request(KIND_TOUCH, 6'd0, 3'd0, 32'd1);
      send_request(KIND_QUERY, 6'd0, 3'd7, '0);             // -> way 1
      send_request(KIND_INSERT, 6'd0, 3'd0, '1);            // insert drops way 0 to LRU
      send_request(KIND_QUERY, 6'd0, 3'd0, '0);
      send_request(KIND_INVALIDATE, 6'd0, 3'd5, '1);
      send_request(KIND_TOUCH, 6'd0, 3'd3, '0);             // promote with time zero
      send_request(KIND_QUERY, 6'd0, 3'd0, '0);
      for (int w = 0; w < 7; w++)
         send_request(KIND_TOUCH, 6'd63, WAY_FBITS'(w), 32'd100);
      send_request(KIND_TOUCH, 6'd63, 3'd7, 32'd50);
      send_request(KIND_QUERY, 6'd63, 3'd0, '0);            // -> way 7
      send_request(KIND_TOUCH, 6'd63, 3'd7, '0);
      send_request(KIND_QUERY, 6'd63, 3'd0, '0);
      send_request(KIND_TOUCH, 6'd63, 3'd7, 32'd200);
      send_request(KIND_QUERY, 6'd63, 3'd0, '0);            // tie on 100 -> way 0
      send_request(KIND_INSERT, 6'd63, 3'd6, '0);
      send_request(KIND_QUERY, 6'd63, 3'd0, '0);
      send_request(KIND_INVALIDATE, 6'd63, 3'd6, '0);
      send_request(KIND_QUERY, 6'd63, 3'd0, '0);

      hammer_phase(300);
      random_phase(60, 8'd255);
      random_phase(60, THRESH_RESET);
      random_phase(60, 8'd1);
      random_phase(60, THRESH_BITS'($urandom_range(0, 255)));
      random_phase(60, THRESH_BITS'($urandom_range(2, 5)));
      random_phase(60, 8'd0);

      // Drain, then let any trailing update retire
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (tracker.mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Victim receiver: random stalls, calm stretches, one long hold-off
   initial begin
      int  stall;
      int  taken;
      bit  calm;
      taken = 0;
      calm  = 0;
      forever begin
         if (taken % 16 == 0) calm = ($urandom_range(0, 2) == 0);
         stall = calm ? 0 : $urandom_range(0, 17);
         if (taken == HOLD_AT) stall = HOLD_OFF;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_victim(rsp_victim_way);
         taken++;
      end
   end

   // Watchdog: end the run when no word moves on any channel for too long
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
